@@ src/qr_function_pattern_classifier_top_defines.svh @@
// ---------------------------------------------------------------------------
// QR function pattern classifier - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef QR_FUNCTION_PATTERN_CLASSIFIER_TOP_DEFINES_SVH
`define QR_FUNCTION_PATTERN_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define QRFPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrfpc: same-cycle check failed");

// next-cycle implication
`define QRFPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrfpc: next-cycle check failed");

`endif

@@ src/qrfpc_pkg.sv @@
// ---------------------------------------------------------------------------
// QR function pattern classifier - package
// Region codes, register indexes and the alignment centre tables.
// ---------------------------------------------------------------------------
package qrfpc_pkg;

   localparam int TABLE_ROWS = 40;
   localparam int TABLE_COLS = 7;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMBOL_VERSION = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIDE_MODULES   = 4'd1;

   localparam logic [5:0] SYMBOL_VERSION_RESET = 6'd0;
   localparam logic [7:0] SIDE_MODULES_RESET   = 8'd21;

   // finder and timing geometry
   localparam logic [8:0] FINDER_SIZE   = 9'd7;
   localparam logic [8:0] FINDER_CENTRE = 9'd3;
   localparam logic [8:0] FINDER_INSET  = 9'd4;
   localparam logic [8:0] SEP_LINE      = 9'd8;
   localparam logic [8:0] TIMING_LINE   = 9'd6;
   localparam logic [8:0] TIMING_END    = 9'd9;
   // an alignment corner below 8 means a centre below 10
   localparam logic [8:0] ALIGN_NEAR    = 9'd10;
   localparam logic [8:0] ALIGN_FAR     = 9'd10;

   typedef enum logic [2:0] {
      REGION_NONE      = 3'd0,
      REGION_FINDER    = 3'd1,
      REGION_SEPARATOR = 3'd2,
      REGION_TIMING    = 3'd3,
      REGION_ALIGNMENT = 3'd4
   } region_type;

   localparam logic [2:0] CENTRE_COUNT [TABLE_ROWS] = '{
      3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6,
      3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
   };

   localparam logic [7:0] CENTRE_TABLE [TABLE_ROWS][TABLE_COLS] = '{
      '{8'd0, 8'd0,  8'd0,  8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd18, 8'd0,  8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd22, 8'd0,  8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd0,  8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd0,  8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd34, 8'd0,  8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd22, 8'd38, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd24, 8'd42, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd46, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd28, 8'd50, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd54, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd32, 8'd58, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd34, 8'd62, 8'd0,  8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd46, 8'd66, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd48, 8'd70, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd50, 8'd74, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd54, 8'd78, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd56, 8'd82, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd58, 8'd86, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd34, 8'd62, 8'd90, 8'd0,   8'd0,   8'd0},
      '{8'd6, 8'd28, 8'd50, 8'd72, 8'd94,  8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd50, 8'd74, 8'd98,  8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd0,   8'd0},
      '{8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd0,   8'd0},
      '{8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd0,   8'd0},
      '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd0,   8'd0},
      '{8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd0,   8'd0},
      '{8'd6, 8'd26, 8'd50, 8'd74, 8'd98,  8'd122, 8'd0},
      '{8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126, 8'd0},
      '{8'd6, 8'd26, 8'd52, 8'd78, 8'd104, 8'd130, 8'd0},
      '{8'd6, 8'd30, 8'd56, 8'd82, 8'd108, 8'd134, 8'd0},
      '{8'd6, 8'd34, 8'd60, 8'd86, 8'd112, 8'd138, 8'd0},
      '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142, 8'd0},
      '{8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd146, 8'd0},
      '{8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126, 8'd150},
      '{8'd6, 8'd24, 8'd50, 8'd76, 8'd102, 8'd128, 8'd154},
      '{8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd132, 8'd158},
      '{8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd136, 8'd162},
      '{8'd6, 8'd26, 8'd54, 8'd82, 8'd110, 8'd138, 8'd166},
      '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142, 8'd170}
   };

   function automatic logic [8:0] abs_diff(input logic [8:0] a, input logic [8:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // Chebyshev distance of exactly two: the light ring of a finder
   function automatic logic on_ring2(input logic [8:0] dr, input logic [8:0] dc);
      logic [8:0] d;
      d = (dr > dc) ? dr : dc;
      on_ring2 = (d == 9'd2);
   endfunction

endpackage

@@ src/qr_function_pattern_classifier_top.sv @@
// ---------------------------------------------------------------------------
// QR function pattern classifier - top level
// A req word accepted goes into the input register, then the result
// register holds the rsp word. Throughput: one word per cycle unless
// rsp_tready stalls the result register; the table lookup and compares
// for a coordinate fit between the two registers. Reset: synchronous,
// active high; empties both stages, symbol_version 0, side_modules 21.
// ---------------------------------------------------------------------------
`include "qr_function_pattern_classifier_top_defines.svh"

module qr_function_pattern_classifier_top
   import qrfpc_pkg::*;
#(
   parameter int VERSION_COUNT    = 40,
   parameter int CENTERS_PER_AXIS = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // row[7:0], column[15:8]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // is_function[0], dark[1], zero[7:2]
   output logic [2:0]                 rsp_tuser,   // region[2:0]
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data
);

   logic [5:0] symbol_version_ff;
   logic [7:0] side_modules_ff;

   logic       req_valid_ff;
   logic [7:0] row_ff;
   logic [7:0] column_ff;
   logic       rsp_valid_ff;
   logic       is_function_ff;
   region_type region_ff;
   logic       dark_ff;

   logic       advance;
   logic       is_function_in;
   region_type region_in;
   logic       dark_in;

   // ---- configuration ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_version_ff <= SYMBOL_VERSION_RESET;
         side_modules_ff   <= SIDE_MODULES_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_SYMBOL_VERSION) begin
            symbol_version_ff <= csr_data[5:0];
         end
         if (csr_index == CSR_SIDE_MODULES) begin
            side_modules_ff <= csr_data;
         end
      end
   end

   // ---- pipeline control ----
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         row_ff    <= req_tdata[7:0];
         column_ff <= req_tdata[15:8];
      end
      if (advance && req_valid_ff) begin
         is_function_ff <= is_function_in;
         region_ff      <= region_in;
         dark_ff        <= dark_in;
      end
   end

   // ---- classification ----
   logic [8:0] r9, c9, side9;
   logic       version_ok;
   logic [5:0] table_idx;

   assign r9         = {1'b0, row_ff};
   assign c9         = {1'b0, column_ff};
   assign side9      = {1'b0, side_modules_ff};
   assign version_ok = int'(symbol_version_ff) < VERSION_COUNT;
   assign table_idx  = version_ok ? symbol_version_ff : 6'd0;

   // one lane per centre of the selected version, row and column side by side
   logic [CENTERS_PER_AXIS-1:0] row_hit, col_hit, near_c, far_c;
   logic [1:0]                  row_dist [CENTERS_PER_AXIS];
   logic [1:0]                  col_dist [CENTERS_PER_AXIS];

   for (genvar k = 0; k < CENTERS_PER_AXIS; k++) begin : g_lane
      logic [8:0] centre9, dr, dc;
      logic       lane_on;
      assign centre9     = {1'b0, CENTRE_TABLE[table_idx][k]};
      assign lane_on     = version_ok && (3'(k) < CENTRE_COUNT[table_idx]);
      assign dr          = abs_diff(r9, centre9);
      assign dc          = abs_diff(c9, centre9);
      assign row_hit[k]  = lane_on && (dr <= 9'd2);
      assign col_hit[k]  = lane_on && (dc <= 9'd2);
      assign row_dist[k] = dr[1:0];
      assign col_dist[k] = dc[1:0];
      assign near_c[k]   = centre9 < ALIGN_NEAR;
      assign far_c[k]    = (centre9 + ALIGN_FAR) >= side9;
   end

   logic       align_hit, align_dark;
   logic [1:0] ar, ac, ad;
   logic       r_near, r_far, c_near, c_far, align_skip;

   // centres lie at least 12 apart, so at most one lane hits per axis
   always_comb begin
      ar = 2'd0;
      ac = 2'd0;
      for (int k = 0; k < CENTERS_PER_AXIS; k++) begin
         ar = ar | (row_hit[k] ? row_dist[k] : 2'd0);
         ac = ac | (col_hit[k] ? col_dist[k] : 2'd0);
      end
      r_near     = |(row_hit & near_c);
      r_far      = |(row_hit & far_c);
      c_near     = |(col_hit & near_c);
      c_far      = |(col_hit & far_c);
      // patterns that would sit on a finder corner
      align_skip = (r_near && c_near) || (r_near && c_far) || (r_far && c_near);
      align_hit  = (|row_hit) && (|col_hit) && !align_skip;
      ad         = (ar > ac) ? ar : ac;
      align_dark = (ad != 2'd1);
   end

   logic in_symbol, top_rows, left_cols, right_cols, bottom_rows;
   logic sep_hit, timing_row, timing_col;

   assign in_symbol   = (r9 < side9) && (c9 < side9);
   assign top_rows    = r9 < FINDER_SIZE;
   assign left_cols   = c9 < FINDER_SIZE;
   assign right_cols  = (c9 + FINDER_SIZE) >= side9;
   assign bottom_rows = (r9 + FINDER_SIZE) >= side9;

   assign sep_hit = (r9 <= FINDER_SIZE && c9 == FINDER_SIZE)
                 || (r9 == FINDER_SIZE && c9 <= FINDER_SIZE)
                 || (r9 <= FINDER_SIZE && (c9 + SEP_LINE) == side9)
                 || (r9 == FINDER_SIZE && (c9 + SEP_LINE) >= side9)
                 || ((r9 + SEP_LINE) >= side9 && c9 == FINDER_SIZE)
                 || ((r9 + SEP_LINE) == side9 && c9 <= FINDER_SIZE);

   assign timing_row = (r9 == TIMING_LINE) && (c9 >= SEP_LINE) && ((c9 + TIMING_END) <= side9);
   assign timing_col = (c9 == TIMING_LINE) && (r9 >= SEP_LINE) && ((r9 + TIMING_END) <= side9);

   always_comb begin
      region_in = REGION_NONE;
      dark_in   = 1'b0;
      priority if (!in_symbol) begin
         region_in = REGION_NONE;
      end else if (top_rows && left_cols) begin
         region_in = REGION_FINDER;
         dark_in   = !on_ring2(abs_diff(r9, FINDER_CENTRE), abs_diff(c9, FINDER_CENTRE));
      end else if (top_rows && right_cols) begin
         region_in = REGION_FINDER;
         dark_in   = !on_ring2(abs_diff(r9, FINDER_CENTRE),
                               abs_diff(c9 + FINDER_INSET, side9));
      end else if (bottom_rows && left_cols) begin
         region_in = REGION_FINDER;
         dark_in   = !on_ring2(abs_diff(r9 + FINDER_INSET, side9),
                               abs_diff(c9, FINDER_CENTRE));
      end else if (sep_hit) begin
         region_in = REGION_SEPARATOR;
      end else if (align_hit) begin
         region_in = REGION_ALIGNMENT;
         dark_in   = align_dark;
      end else if (timing_row) begin
         region_in = REGION_TIMING;
         dark_in   = !c9[0];
      end else if (timing_col) begin
         region_in = REGION_TIMING;
         dark_in   = !r9[0];
      end else begin
         // data area inside the symbol
         region_in = REGION_NONE;
      end
      is_function_in = (region_in != REGION_NONE);
   end

   // ---- result word ----
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, dark_ff, is_function_ff};
   assign rsp_tuser  = region_ff;

   // ---- checks ----
   `QRFPC_ASSERT_NOW(a_flag_matches_region, clock, reset, rsp_tvalid, is_function_ff == (region_ff != REGION_NONE))
   `QRFPC_ASSERT_NOW(a_light_when_not_function, clock, reset, rsp_tvalid && !is_function_ff, !dark_ff)
   `QRFPC_ASSERT_NOW(a_separator_light, clock, reset, rsp_tvalid && region_ff == REGION_SEPARATOR, !dark_ff)
   `QRFPC_ASSERT_NEXT(a_stage_held, clock, reset, req_valid_ff && !advance, req_valid_ff)

endmodule
